### hdl/lob_pkg.sv
// Package for the order book block: field widths, codes, shared constants.
// No dependencies.
`timescale 1ns / 1ps
package lob_pkg;
  localparam int ORDER_SLOTS_DEF  = 4096;
  localparam int PRICE_LEVELS_DEF = 256;
  localparam int PRICE_W = 32;
  localparam int SIZE_W  = 32;
  localparam int VOL_W   = 48;
  localparam int CNT_W   = 13;
  localparam int ID_W    = 12;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_EXEC   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNKNOWN   = 2'd1;
  localparam logic [1:0] ST_PRICE_OOR = 2'd2;
  localparam logic [1:0] ST_ID_OOR    = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [ID_W-1:0]    oid;
    logic [PRICE_W-1:0] price;
    logic [SIZE_W-1:0]  size;
    logic               side;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               best_bid_valid;
    logic [PRICE_W-1:0] bid_px;
    logic [VOL_W-1:0]   bid_vol;
    logic               best_ask_valid;
    logic [PRICE_W-1:0] ask_px;
    logic [VOL_W-1:0]   ask_vol;
  } out_item_t;
endpackage

### hdl/lob_stream_if.sv
// Valid/ready channel carrying one payload item.
// No dependencies; the payload type is a parameter.
`timescale 1ns / 1ps
interface lob_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/lob_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module lob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/lob_core.sv
// Message engine: order table and level memories, top-of-book tracking.
// Depends on lob_pkg and lob_ram.
`timescale 1ns / 1ps
module lob_core
  import lob_pkg::*;
#(
  parameter int ORDER_SLOTS  = ORDER_SLOTS_DEF,
  parameter int PRICE_LEVELS = PRICE_LEVELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic [PRICE_W-1:0] base_price
);
  localparam int OA    = $clog2(ORDER_SLOTS);
  localparam int LW    = $clog2(PRICE_LEVELS);
  localparam int LA    = LW + 1;
  localparam int LH    = 2 ** LW;
  localparam int NL    = 2 * LH;
  localparam int CLR_N = (ORDER_SLOTS > NL) ? ORDER_SLOTS : NL;
  localparam int CW    = $clog2(CLR_N) + 1;
  localparam int EW    = 1 + LW + SIZE_W;
  localparam int LVW   = VOL_W + CNT_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_LVL   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_TOPRD = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    clr_r;
  in_item_t         it_r;
  logic [1:0]       status_r, status_nxt;
  logic             act_r, act_nxt;
  logic [LA-1:0]    slot_r;
  logic [SIZE_W-1:0] dsize_r;
  logic             is_add_r;
  logic [NL-1:0]    nonempty_r;
  logic             bid_v_r, ask_v_r;
  logic [LW-1:0]    bid_i_r, ask_i_r;
  logic [VOL_W-1:0] bid_vol_r;
  out_item_t        out_r;
  logic             out_valid_r;

  // order table: live bit and entry kept together, cleared by a sweep
  logic            o_we;
  logic [OA-1:0]   o_waddr, o_raddr;
  logic [EW:0]     o_wdata, o_rdata;
  logic            l_we;
  logic [LA-1:0]   l_waddr, l_raddr;
  logic [LVW-1:0]  l_wdata, l_rdata;

  lob_ram #(.WIDTH(EW + 1), .DEPTH(ORDER_SLOTS)) u_order (
    .clk, .we(o_we), .waddr(o_waddr), .wdata(o_wdata), .raddr(o_raddr), .rdata(o_rdata));
  lob_ram #(.WIDTH(LVW), .DEPTH(NL)) u_level (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(l_raddr), .rdata(l_rdata));

  logic            id_oor, price_oor;
  logic [PRICE_W-1:0] pdiff;
  logic            e_live, e_side;
  logic [LW-1:0]   e_lvl;
  logic [SIZE_W-1:0] e_size;
  logic [VOL_W-1:0] cur_vol, new_vol;
  logic [CNT_W-1:0] cur_cnt, new_cnt;
  logic            bid_any, ask_any;
  logic [LW-1:0]   bid_idx, ask_idx;

  assign pdiff     = it_r.price - base_price;
  assign price_oor = (it_r.price < base_price) || (pdiff >= PRICE_W'(PRICE_LEVELS));
  assign id_oor    = 32'(it_r.oid) >= 32'(ORDER_SLOTS);
  assign {e_live, e_side, e_lvl, e_size} = o_rdata;
  assign {cur_vol, cur_cnt} = l_rdata;

  // level update arithmetic
  always_comb begin
    if (is_add_r) begin
      new_vol = cur_vol + VOL_W'(dsize_r);
      new_cnt = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
    end else begin
      new_vol = cur_vol - VOL_W'(dsize_r);
      new_cnt = (cur_cnt == '0) ? cur_cnt : cur_cnt - 1'b1;
    end
  end

  // decode status and whether the book changes
  always_comb begin
    status_nxt = ST_OK;
    act_nxt    = 1'b0;
    if (it_r.func == FUNC_ADD || it_r.func == FUNC_CANCEL || it_r.func == FUNC_EXEC) begin
      if (id_oor) status_nxt = ST_ID_OOR;
      else if (it_r.func == FUNC_ADD) begin
        if (price_oor) status_nxt = ST_PRICE_OOR;
        else act_nxt = 1'b1;
      end else if (!e_live) status_nxt = ST_UNKNOWN;
      else act_nxt = 1'b1;
    end
  end

  // priority search over non-empty flags
  always_comb begin
    bid_any = 1'b0; ask_any = 1'b0; bid_idx = '0; ask_idx = '0;
    for (int i = 0; i < PRICE_LEVELS; i++) begin
      if (nonempty_r[LH + i]) begin
        bid_any = 1'b1; bid_idx = LW'(i);
      end
    end
    for (int i = PRICE_LEVELS - 1; i >= 0; i--) begin
      if (nonempty_r[i]) begin
        ask_any = 1'b1; ask_idx = LW'(i);
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // memory port steering
  always_comb begin
    o_we = 1'b0; o_waddr = OA'(it_r.oid); o_wdata = '0;
    o_raddr = OA'(in_data.oid);
    l_we = 1'b0; l_waddr = slot_r; l_wdata = {new_vol, new_cnt};
    l_raddr = slot_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r < CW'(ORDER_SLOTS)) begin
          o_we = 1'b1; o_waddr = clr_r[OA-1:0];
        end
        if (clr_r < CW'(NL)) begin
          l_we = 1'b1; l_waddr = clr_r[LA-1:0]; l_wdata = '0;
        end
      end
      S_READ: begin
        if (it_r.func == FUNC_ADD) begin
          l_raddr = {it_r.side, pdiff[LW-1:0]};
        end else begin
          l_raddr = {e_side, e_lvl};
        end
      end
      S_LVL: begin
        l_we = act_r;
        o_we = act_r;
        o_wdata = is_add_r ? {1'b1, it_r.side, pdiff[LW-1:0], it_r.size} : '0;
      end
      S_SCAN: begin
        l_raddr = {1'b1, bid_idx};
      end
      S_TOPRD: begin
        l_raddr = {1'b0, ask_i_r};
      end
      S_OUT: begin
        l_raddr = {1'b0, ask_i_r};
      end
      default: ;
    endcase
  end

  // control sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == CW'(CLR_N - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_READ;
      S_READ:  state_nxt = S_LVL;
      S_LVL:   state_nxt = S_SCAN;
      S_SCAN:  state_nxt = S_TOPRD;
      S_TOPRD: state_nxt = S_OUT;
      S_OUT:   if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      nonempty_r <= '0;
      out_valid_r <= 1'b0;
      act_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // raise valid on a new result, drop it once taken
      if (state_r == S_OUT && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: clr_r <= clr_r + 1'b1;
        S_IDLE: if (in_valid) it_r <= in_data;
        S_READ: begin
          act_r <= act_nxt;
          is_add_r <= (it_r.func == FUNC_ADD);
          status_r <= status_nxt;
          if (it_r.func == FUNC_ADD) begin
            slot_r <= {it_r.side, pdiff[LW-1:0]};
            dsize_r <= it_r.size;
          end else begin
            slot_r <= {e_side, e_lvl};
            dsize_r <= e_size;
          end
        end
        S_LVL: begin
          if (act_r) nonempty_r[slot_r] <= (new_cnt != '0);
        end
        S_SCAN: begin
          bid_v_r <= bid_any; bid_i_r <= bid_idx;
          ask_v_r <= ask_any; ask_i_r <= ask_idx;
        end
        S_TOPRD: begin
          bid_vol_r <= bid_v_r ? l_rdata[LVW-1:CNT_W] : '0;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r.status <= status_r;
            out_r.best_bid_valid <= bid_v_r;
            out_r.bid_px <= bid_v_r ? base_price + PRICE_W'(bid_i_r) : '0;
            out_r.bid_vol <= bid_vol_r;
            out_r.best_ask_valid <= ask_v_r;
            out_r.ask_px <= ask_v_r ? base_price + PRICE_W'(ask_i_r) : '0;
            out_r.ask_vol <= ask_v_r ? l_rdata[LVW-1:CNT_W] : '0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### hdl/limit_order_book_levels.sv
// Limit order book, price-level form.
// Takes add/cancel/execute items on in_, returns status and top of book on out_.
// Each item is accepted when in_valid and in_ready are high; one result follows.
// out_valid rises after the READ, LVL, SCAN, TOPRD and OUT states. in_ready
// is high only while the engine is idle, so no item is taken until the last one
// leaves OUT. The steps are the order table read, the level read-modify-write and
// the two best-level volume reads, all on the single read port of each memory.
// base_price is written on the cfg_ channel (always ready); write it only idle.
// Reset: rst_n low synchronously; afterwards a clearing pass sized by ORDER_SLOTS
// (or twice the level table, if that is larger) sweeps the order table
// and level memory, with in_ready low.
// Stall: when out_ready is low the result holds; one more item may be taken,
// and its result waits in the output stage until the held one has gone.
// Depends on lob_pkg, lob_stream_if, lob_core, lob_ram.
`timescale 1ns / 1ps
module limit_order_book_levels
  import lob_pkg::*;
#(
  parameter int ORDER_SLOTS  = ORDER_SLOTS_DEF,
  parameter int PRICE_LEVELS = PRICE_LEVELS_DEF
) (
  input logic clk,
  input logic rst_n,
  lob_stream_if.sink   in_ch,
  lob_stream_if.source out_ch,
  lob_stream_if.sink   cfg_ch
);
  logic [PRICE_W-1:0] base_price_r;

  // register write: always accepted
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_price_r <= '0;
    end else if (cfg_ch.valid) begin
      base_price_r <= cfg_ch.data;
    end
  end

  lob_core #(.ORDER_SLOTS(ORDER_SLOTS), .PRICE_LEVELS(PRICE_LEVELS)) u_core (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .base_price(base_price_r));
endmodule

### tb/sv/lob_book_checker.sv
// Checker for the order book block: watches the item, result and write channels,
// keeps its own copy of the book, and compares every result in order.
// Depends on lob_pkg.
`timescale 1ns / 1ps
module lob_book_checker
  import lob_pkg::*;
#(
  parameter int SLOTS  = ORDER_SLOTS_DEF,
  parameter int LEVELS = PRICE_LEVELS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_item_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_item_t out_data,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [PRICE_W-1:0] cfg_data,
  output int   fail_count,
  output int   pending_tops,
  output int   results_seen
);
  typedef struct {
    logic               side;
    int unsigned        level;
    logic [SIZE_W-1:0]  size;
  } order_rec_t;

  logic [PRICE_W-1:0] base;
  bit                 live [SLOTS];
  order_rec_t         book_order [SLOTS];
  logic [VOL_W-1:0]   lvl_vol [2*LEVELS];
  logic [CNT_W-1:0]   lvl_cnt [2*LEVELS];
  out_item_t          expected_tops [$];

  // Apply one message to the book and return the status plus top of book.
  function automatic out_item_t apply_message(in_item_t m);
    out_item_t r;
    int unsigned s;
    logic [PRICE_W-1:0] off;
    r = '0;
    r.status = ST_OK;
    if (m.func != 2'd3) begin
      if (m.oid >= SLOTS) begin
        r.status = ST_ID_OOR;
      end else if (m.func == FUNC_ADD) begin
        off = m.price - base;
        if (m.price < base || off >= LEVELS) begin
          r.status = ST_PRICE_OOR;
        end else begin
          s = m.side * LEVELS + off;
          live[m.oid] = 1;
          book_order[m.oid] = '{m.side, off, m.size};
          lvl_vol[s] = lvl_vol[s] + m.size;
          if (lvl_cnt[s] != COUNT_MAX) lvl_cnt[s]++;
        end
      end else if (!live[m.oid]) begin
        r.status = ST_UNKNOWN;
      end else begin
        s = book_order[m.oid].side * LEVELS + book_order[m.oid].level;
        live[m.oid] = 0;
        lvl_vol[s] = lvl_vol[s] - book_order[m.oid].size;
        if (lvl_cnt[s] != 0) lvl_cnt[s]--;
      end
    end
    // Scan bids down from the top, asks up from the bottom.
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (lvl_cnt[LEVELS + i] != 0) begin
        r.best_bid_valid = 1;
        r.bid_px         = base + i;
        r.bid_vol        = lvl_vol[LEVELS + i];
        break;
      end
    end
    for (int i = 0; i < LEVELS; i++) begin
      if (lvl_cnt[i] != 0) begin
        r.best_ask_valid = 1;
        r.ask_px         = base + i;
        r.ask_vol        = lvl_vol[i];
        break;
      end
    end
    return r;
  endfunction

  assign pending_tops = expected_tops.size();

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      base = '0;
      fail_count = 0;
      results_seen = 0;
      expected_tops.delete();
      for (int i = 0; i < SLOTS; i++) live[i] = 0;
      for (int i = 0; i < 2*LEVELS; i++) begin
        lvl_vol[i] = '0;
        lvl_cnt[i] = '0;
      end
    end else begin
      // Compare a result first, against the state before this edge's item.
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_tops.size() == 0) begin
          $error("result with no item outstanding");
          fail_count++;
        end else begin
          e = expected_tops.pop_front();
          if (out_data.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, out_data.status);
            fail_count++;
          end
          if (out_data.best_bid_valid !== e.best_bid_valid) begin
            $error("best_bid_valid: expected %0d actual %0d",
                   e.best_bid_valid, out_data.best_bid_valid);
            fail_count++;
          end
          if (out_data.bid_px !== e.bid_px) begin
            $error("bid_px: expected %0d actual %0d",
                   e.bid_px, out_data.bid_px);
            fail_count++;
          end
          if (out_data.bid_vol !== e.bid_vol) begin
            $error("bid_vol: expected %0d actual %0d",
                   e.bid_vol, out_data.bid_vol);
            fail_count++;
          end
          if (out_data.best_ask_valid !== e.best_ask_valid) begin
            $error("best_ask_valid: expected %0d actual %0d",
                   e.best_ask_valid, out_data.best_ask_valid);
            fail_count++;
          end
          if (out_data.ask_px !== e.ask_px) begin
            $error("ask_px: expected %0d actual %0d",
                   e.ask_px, out_data.ask_px);
            fail_count++;
          end
          if (out_data.ask_vol !== e.ask_vol) begin
            $error("ask_vol: expected %0d actual %0d",
                   e.ask_vol, out_data.ask_vol);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) base = cfg_data;
      if (in_valid && in_ready) expected_tops.push_back(apply_message(in_data));
    end
  end
endmodule

### tb/sv/tb_limit_order_book_levels.sv
// Top of the order book testbench: clock, reset, message stimulus, verdict.
// Depends on lob_pkg, lob_stream_if, lob_book_checker and the block itself.
`timescale 1ns / 1ps
module tb_limit_order_book_levels
  import lob_pkg::*;
();

  localparam int LEVELS = PRICE_LEVELS_DEF;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  int   fail_count, pending_tops, results_seen;
  longint cycles = 0;
  int   items_sent;
  logic [PRICE_W-1:0] cur_base;
  int unsigned used_ids [$];

  lob_stream_if #(in_item_t)           in_ch ();
  lob_stream_if #(out_item_t)          out_ch ();
  lob_stream_if #(logic [PRICE_W-1:0]) cfg_ch ();

  limit_order_book_levels dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  lob_book_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_valid(cfg_ch.valid), .cfg_ready(cfg_ch.ready), .cfg_data(cfg_ch.data),
    .fail_count(fail_count), .pending_tops(pending_tops),
    .results_seen(results_seen)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random stall before each result, with stretches of none.
  initial begin
    int n;
    bit burst;
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 49) == 0) burst = !burst;
      n = burst ? 0 : $urandom_range(0, 8);
      if (n != 0) begin
        out_ch.ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      out_ch.ready <= 0;
    end
  end

  // Hold valid across back-to-back items; drop it only for a gap.
  task automatic send_message(input in_item_t m, input bit no_gap);
    int n;
    n = no_gap ? 0 : $urandom_range(0, 8);
    if (n != 0) begin
      in_ch.valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data  <= m;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending_tops != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_base(input logic [PRICE_W-1:0] v);
    cfg_ch.valid <= 1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
    cur_base = v;
  endtask

  function automatic in_item_t make_msg(logic [1:0] f, int unsigned id,
                                        logic [PRICE_W-1:0] p,
                                        logic [SIZE_W-1:0] sz, logic sd);
    in_item_t m;
    m.func = f; m.oid = ID_W'(id); m.price = p; m.size = sz; m.side = sd;
    return m;
  endfunction

  // One random message, mostly well-formed adds, and cancels or executes of used ids.
  task automatic random_message(input bit no_gap);
    in_item_t m;
    int unsigned k;
    int unsigned id;
    k = $urandom_range(0, 99);
    m.price = cur_base + $urandom_range(0, LEVELS - 1);
    m.size  = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 1000);
    m.side  = 1'($urandom_range(0, 1));
    if (k < 50) begin
      // Cluster ids so cancels find live orders.
      id = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 63);
      m.func = FUNC_ADD;
      m.oid = ID_W'(id);
      if ($urandom_range(0, 9) == 0) m.price = $urandom();
      used_ids.push_back(id);
    end else if (k < 90) begin
      m.func = ($urandom_range(0, 1) != 0) ? FUNC_CANCEL : FUNC_EXEC;
      if (used_ids.size() != 0 && $urandom_range(0, 4) != 0)
        m.oid = ID_W'(used_ids[$urandom_range(0, used_ids.size() - 1)]);
      else
        m.oid = ID_W'($urandom_range(0, 4095));
    end else begin
      m.func = 2'($urandom_range(0, 3));
      m.oid = ID_W'($urandom_range(0, 4095));
      m.price = $urandom();
      m.size = $urandom();
    end
    send_message(m, no_gap);
  endtask

  initial begin
    items_sent = 0;
    cur_base = '0;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.data = '0;
    cfg_ch.valid = 0;
    cfg_ch.data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // Directed: extremes, every operation, unknown ids and out-of-range prices.
    send_message(make_msg(FUNC_ADD, 0, 32'd0, 32'hFFFF_FFFF, 1'b1), 0);
    send_message(make_msg(FUNC_ADD, 4095, LEVELS - 1, 32'd0, 1'b0), 0);
    send_message(make_msg(FUNC_ADD, 1, LEVELS, 32'd5, 1'b1), 0);
    send_message(make_msg(FUNC_ADD, 2, 32'hFFFF_FFFF, 32'd5, 1'b0), 0);
    send_message(make_msg(FUNC_ADD, 3, 32'd0, 32'hFFFF_FFFF, 1'b1), 0);
    send_message(make_msg(FUNC_ADD, 3, 32'd7, 32'd9, 1'b0), 0);
    send_message(make_msg(FUNC_CANCEL, 5, 32'd0, 32'd0, 1'b0), 0);
    send_message(make_msg(FUNC_EXEC, 0, 32'd0, 32'd0, 1'b0), 0);
    send_message(make_msg(FUNC_CANCEL, 3, 32'd0, 32'd0, 1'b0), 0);
    send_message(make_msg(2'd3, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1), 0);
    send_message(make_msg(FUNC_EXEC, 4095, 32'd0, 32'd0, 1'b0), 0);
    send_message(make_msg(FUNC_CANCEL, 3, 32'd0, 32'd0, 1'b0), 0);
    wait_idle();

    // Base near the top of the range: prices that wrap past the top or lie below it are out of range.
    write_base(32'hFFFF_FFF0);
    send_message(make_msg(FUNC_ADD, 10, 32'hFFFF_FFFF, 32'd3, 1'b1), 0);
    send_message(make_msg(FUNC_ADD, 11, 32'hFFFF_FFF0, 32'd4, 1'b0), 0);
    send_message(make_msg(FUNC_ADD, 12, 32'd5, 32'd4, 1'b0), 0);
    send_message(make_msg(FUNC_ADD, 13, 32'hFFFF_FFEF, 32'd4, 1'b0), 0);
    wait_idle();
    write_base(32'd100);
    send_message(make_msg(FUNC_CANCEL, 10, 32'd0, 32'd0, 1'b0), 0);
    send_message(make_msg(FUNC_EXEC, 11, 32'd0, 32'd0, 1'b0), 0);
    wait_idle();

    // Random phases across several bases, extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_base(32'd0);
        1: write_base(32'hFFFF_FFFF);
        2: write_base($urandom());
        default: write_base($urandom_range(0, 1000));
      endcase
      for (int i = 0; i < 190; i++) begin
        random_message($urandom_range(0, 5) == 0);
        if (i == 95) wait_idle();
      end
      wait_idle();
    end

    wait_idle();
    $display("Sent %0d items and checked %0d results across seven base writes,",
             items_sent, results_seen);
    $display("with random gaps and stalls on both channels.");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

### filelist.f
hdl/lob_pkg.sv
hdl/lob_stream_if.sv
hdl/lob_ram.sv
hdl/lob_core.sv
hdl/limit_order_book_levels.sv
tb/sv/lob_book_checker.sv
tb/sv/tb_limit_order_book_levels.sv
